/* src/bfa_pkg.sv */
// Shared definitions for the bitmap frame allocator.
// Holds command codes, field widths and the sequencer state type.
// No dependencies.
package bfa_pkg;

    // Field widths of the request and result ports
    localparam int ADDR_W = 26;
    localparam int CFG_W  = 27;
    localparam int CMD_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ASCAN,
        S_AWRITE,
        S_FREAD,
        S_FWRITE,
        S_DONE
    } t_state;

endpackage

/* src/bitmap_frame_allocator.sv */
// First-fit page frame allocator: one used bit per frame in a word-wide bitmap memory.
// Depends on bfa_pkg (widths, command codes, state type).
// Holds the sequencer, the bitmap memory and the word scan logic.

// A request is taken when start is high and busy is low; busy stays high until the
// single result has been shown on o_frame_address with o_valid high for one cycle.
// The result cannot be held off, so the receiver must take it in that cycle.
// Alloc reads one bitmap word per cycle starting at the lowest word that may hold a free
// frame, and ends at the first word with a free frame or after the last word.
// Free splits the address into word and bit with shifts, then reads and writes that
// word; an address of zero or past the last frame changes nothing.
// Init writes every bitmap word once, one per cycle.
// An unused command code changes nothing and returns zero. FRAME_BYTES and WORD_BITS
// must be powers of two. The bitmap holds no defined value until the first init.
module bitmap_frame_allocator #(
    parameter int FRAME_COUNT = 16384,
    parameter int FRAME_BYTES = 4096,
    parameter int WORD_BITS   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bfa_pkg::CMD_W-1:0]    i_command,
    input  logic [bfa_pkg::ADDR_W-1:0]   i_address,
    input  logic                         i_cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                         o_valid,
    output logic [bfa_pkg::ADDR_W-1:0]   o_frame_address
);
    import bfa_pkg::*;

    // Derived sizes
    localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRW        = $clog2(FRAME_COUNT);
    localparam int FCW        = $clog2(FRAME_COUNT + 1);
    localparam int FB_SH      = $clog2(FRAME_BYTES);
    localparam int DW         = CFG_W + 1;
    localparam int MW         = FRW + BIT_W + 1;
    localparam int PW0        = FRW + $clog2(FRAME_BYTES + 1);
    localparam int PW         = (PW0 > ADDR_W) ? PW0 : ADDR_W;
    localparam int LAST_BITS  = FRAME_COUNT - (WORD_COUNT - 1) * WORD_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_COUNT - 1);

    // Control registers
    t_state             r_state, n_state;
    logic               r_rdv, n_rdv;
    logic [IDX_W-1:0]   r_hint, n_hint;
    logic [CFG_W-1:0]   r_reserved;

    // Datapath registers
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]    r_widx, n_widx;
    logic [WORD_BITS-1:0] r_wdata, n_wdata;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [FRW-1:0]      r_frame, n_frame;
    logic [ADDR_W-1:0]   r_result, n_result;
    logic [FCW-1:0]      r_remain, n_remain;

    // Bitmap memory
    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [WORD_BITS-1:0] mem_wd;

    // Request decode
    logic [ADDR_W-1:0]    free_frame;
    logic [DW-1:0]        init_dnd;
    logic [DW-1:0]        init_lim;

    // Scan helpers
    logic [WORD_BITS-1:0] pad_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     pe_bit;
    logic                 pe_found;
    logic [WORD_BITS-1:0] init_word;
    logic [PW-1:0]        prod;

    // Frame of a free request and the rounded-up reserved frame count
    assign free_frame = i_address >> FB_SH;
    assign init_dnd   = DW'(r_reserved) + DW'(FRAME_BYTES - 1);
    assign init_lim   = init_dnd >> FB_SH;

    // Bits past the last frame count as used in the last word
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            pad_mask[j] = (r_rd_idx == LAST_IDX) && (j >= LAST_BITS);
        end
    end
    assign free_bits = ~(r_rdata | pad_mask);

    // Lowest free bit of the word just read
    always_comb begin
        pe_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                pe_bit = BIT_W'(j);
            end
        end
    end
    assign pe_found = |free_bits;

    // Init word: frames still below the reserved limit are marked used
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            init_word[j] = (FCW'(j) < r_remain);
        end
    end

    assign prod = PW'(r_frame) * PW'(FRAME_BYTES);

    // Next state and datapath control
    always_comb begin
        n_state  = r_state;
        n_rdv    = r_rdv;
        n_hint   = r_hint;
        n_ptr    = r_ptr;
        n_rd_idx = r_rd_idx;
        n_widx   = r_widx;
        n_wdata  = r_wdata;
        n_bit    = r_bit;
        n_frame  = r_frame;
        n_result = r_result;
        n_remain = r_remain;
        mem_we   = 1'b0;
        mem_wa   = r_ptr;
        mem_wd   = init_word;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_result = '0;
                    if (i_command == CMD_ALLOC) begin
                        n_ptr   = r_hint;
                        n_rdv   = 1'b0;
                        n_state = S_ASCAN;
                    end else if (i_command == CMD_FREE) begin
                        // Address zero and frames past the end are ignored
                        if ((i_address == '0) || (free_frame >= ADDR_W'(FRAME_COUNT))) begin
                            n_state = S_DONE;
                        end else begin
                            n_ptr   = IDX_W'(free_frame >> BIT_W);
                            n_bit   = free_frame[BIT_W-1:0];
                            n_state = S_FREAD;
                        end
                    end else if (i_command == CMD_INIT) begin
                        // Limit saturates at the frame count; frame 0 is always reserved
                        if (init_lim >= DW'(FRAME_COUNT)) begin
                            n_remain = FCW'(FRAME_COUNT);
                        end else if (init_lim == '0) begin
                            n_remain = FCW'(1);
                        end else begin
                            n_remain = FCW'(init_lim);
                        end
                        n_ptr   = '0;
                        n_state = S_INIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_INIT: begin
                mem_we   = 1'b1;
                mem_wa   = r_ptr;
                mem_wd   = init_word;
                n_remain = (r_remain > FCW'(WORD_BITS)) ? (r_remain - FCW'(WORD_BITS)) : '0;
                n_ptr    = r_ptr + IDX_W'(1);
                if (r_ptr == LAST_IDX) begin
                    n_hint  = '0;
                    n_state = S_DONE;
                end
            end

            S_ASCAN: begin
                // Read one word per cycle, check the word read the cycle before
                n_ptr    = r_ptr + IDX_W'(1);
                n_rd_idx = r_ptr;
                n_rdv    = 1'b1;
                if (r_rdv && pe_found) begin
                    n_widx  = r_rd_idx;
                    n_wdata = r_rdata | (WORD_BITS'(1) << pe_bit);
                    n_frame = FRW'(MW'(r_rd_idx) * MW'(WORD_BITS) + MW'(pe_bit));
                    n_state = S_AWRITE;
                end else if (r_rdv && (r_rd_idx == LAST_IDX)) begin
                    n_state = S_DONE;
                end
            end

            S_AWRITE: begin
                mem_we   = 1'b1;
                mem_wa   = r_widx;
                mem_wd   = r_wdata;
                n_hint   = r_widx;
                n_result = prod[ADDR_W-1:0];
                n_state  = S_DONE;
            end

            S_FREAD: begin
                n_state = S_FWRITE;
            end

            S_FWRITE: begin
                mem_we  = 1'b1;
                mem_wa  = r_ptr;
                mem_wd  = r_rdata & ~(WORD_BITS'(1) << r_bit);
                if (r_ptr < r_hint) begin
                    n_hint = r_ptr;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rdv      <= 1'b0;
            r_hint     <= '0;
            r_reserved <= '0;
        end else begin
            r_state <= n_state;
            r_rdv   <= n_rdv;
            r_hint  <= n_hint;
            if (i_cfg_we) begin
                r_reserved <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_rd_idx <= n_rd_idx;
        r_widx   <= n_widx;
        r_wdata  <= n_wdata;
        r_bit    <= n_bit;
        r_frame  <= n_frame;
        r_result <= n_result;
        r_remain <= n_remain;
    end

    // Bitmap memory: one write port, registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[r_ptr];
    end

    // Outputs
    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_DONE);
    assign o_frame_address = r_result;

endmodule

/* sim/bitmap_frame_allocator_tb.sv */
// Self-checking testbench for bitmap_frame_allocator: directed corner cases, then random
// alloc/free/init traffic checked against an in-bench bitmap of used frames.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL.
`timescale 1ns / 100ps

module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    localparam int FRAME_COUNT = 16384;
    localparam int FRAME_BYTES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = FRAME_COUNT / WORD_BITS;
    localparam int MEM_BYTES   = FRAME_COUNT * FRAME_BYTES;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  i_command;
    logic [ADDR_W-1:0] i_address;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              o_valid;
    logic [ADDR_W-1:0] o_frame_address;

    // Bench copy of the bitmap and the reserved-end register
    logic [WORD_BITS-1:0] used_words [WORD_COUNT];
    logic [CFG_W-1:0]     reserved_end;

    logic [ADDR_W-1:0] pending_frames [$];  // expected frame addresses, oldest first
    int unsigned       held_frames [$];     // frames handed out, candidates for free
    logic [ADDR_W-1:0] want_frame;
    bit                failed;
    bit                steady_feed;         // no gaps between requests when set

    bitmap_frame_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_frame_address (o_frame_address)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Apply one request to the bench bitmap and return the expected frame address
    function automatic logic [ADDR_W-1:0] predict_request(logic [CMD_W-1:0] cmd,
                                                          logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] frame_addr;
        int unsigned       limit;
        int unsigned       f;
        bit                found;
        frame_addr = '0;
        found      = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                for (int w = 0; w < WORD_COUNT && !found; w++) begin
                    if (used_words[w] != '1) begin
                        for (int b = 0; b < WORD_BITS && !found; b++) begin
                            if (!used_words[w][b]) begin
                                used_words[w][b] = 1'b1;
                                frame_addr = ADDR_W'((w * WORD_BITS + b) * FRAME_BYTES);
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_FREE: begin
                // address zero is ignored; any address below one frame clears frame 0
                if (addr != '0) begin
                    f = addr / FRAME_BYTES;
                    if (f < FRAME_COUNT)
                        used_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
                end
            end
            CMD_INIT: begin
                limit = (int'(reserved_end) + FRAME_BYTES - 1) / FRAME_BYTES;
                if (limit > FRAME_COUNT)
                    limit = FRAME_COUNT;
                for (int w = 0; w < WORD_COUNT; w++)
                    used_words[w] = '0;
                used_words[0][0] = 1'b1;
                for (f = 0; f < limit; f++)
                    used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
            end
            default: ;
        endcase
        return frame_addr;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    // Check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: result with none expected: actual %h", $time, o_frame_address);
                failed = 1'b1;
            end else begin
                want_frame = pending_frames.pop_front();
                if (o_frame_address !== want_frame) begin
                    $display("%0t: frame_address mismatch: expected %h actual %h",
                             $time, want_frame, o_frame_address);
                    failed = 1'b1;
                end
            end
        end
    end

    // Send one request; start stays high across back-to-back requests
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        int unsigned       gap;
        logic [ADDR_W-1:0] frame_addr;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        do @(posedge i_clk); while (busy);
        frame_addr = predict_request(cmd, addr);
        pending_frames.push_back(frame_addr);
        if (cmd == CMD_INIT)
            held_frames.delete();
        else if (cmd == CMD_ALLOC && frame_addr != '0)
            held_frames.push_back(frame_addr / FRAME_BYTES);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; only called with the block idle
    task automatic write_reserved(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reserved_end = value;
    endtask

    // Init with no reservation, allocs, ignored commands
    task automatic test_basic_alloc();
        write_reserved('0);
        send_request(CMD_INIT, 26'h3FF_FFFF);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, 26'h155_5555);
        send_request(CMD_NOP, 26'h2AA_AAAA);
        send_request(CMD_FREE, '0);
        send_request(CMD_ALLOC, '0);
        drain();
    endtask

    // Low addresses clear frame 0; top address clears the last frame
    task automatic test_free_edges();
        send_request(CMD_FREE, 26'd1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, ADDR_W'(FRAME_BYTES - 1));
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, 26'h3FF_FFFF);
        drain();
    endtask

    // Reserved end not on a frame boundary rounds up
    task automatic test_partial_reserve();
        write_reserved(CFG_W'(FRAME_BYTES + 1));
        send_request(CMD_INIT, '0);
        send_request(CMD_ALLOC, '0);
        drain();
    endtask

    // Last three frames free: use them up, alloc on full memory, then recycle one
    task automatic test_memory_full();
        write_reserved(CFG_W'(MEM_BYTES - 3 * FRAME_BYTES));
        send_request(CMD_INIT, '0);
        repeat (4) send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, 26'h3FF_FFFF);
        send_request(CMD_ALLOC, '0);
        drain();
    endtask

    // Reservation covering all of memory
    task automatic test_reserve_all();
        write_reserved(CFG_W'(MEM_BYTES));
        send_request(CMD_INIT, '0);
        send_request(CMD_ALLOC, '0);
        drain();
    endtask

    // Random phases: new reservation, init, then mostly alloc/free of held frames
    task automatic test_random_traffic();
        int unsigned       r;
        int unsigned       idx;
        logic [CFG_W-1:0]  resv;
        logic [ADDR_W-1:0] addr;
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: resv = CFG_W'($urandom_range(0, 200000));
                1: resv = CFG_W'(MEM_BYTES - $urandom_range(0, 30) * FRAME_BYTES);
                2: resv = CFG_W'($urandom_range(0, MEM_BYTES));
                default: resv = (p % 8 == 3) ? '0 : CFG_W'(MEM_BYTES);
            endcase
            steady_feed = (p % 3 == 2);
            write_reserved(resv);
            send_request(CMD_INIT, ADDR_W'($urandom()));
            for (int n = 0; n < 102; n++) begin
                r = $urandom_range(0, 99);
                if (r < 48) begin
                    send_request(CMD_ALLOC, ADDR_W'($urandom()));
                end else if (r < 90) begin
                    if (held_frames.size() != 0 && $urandom_range(0, 4) != 0) begin
                        idx  = $urandom_range(0, held_frames.size() - 1);
                        addr = ADDR_W'(held_frames[idx] * FRAME_BYTES
                                       + $urandom_range(0, FRAME_BYTES - 1));
                        held_frames.delete(idx);
                    end else begin
                        addr = ADDR_W'($urandom());
                    end
                    send_request(CMD_FREE, addr);
                end else if (r < 93) begin
                    send_request(CMD_NOP, ADDR_W'($urandom()));
                end else if (r < 95) begin
                    send_request(CMD_INIT, ADDR_W'($urandom()));
                end else if (r < 97) begin
                    send_request(CMD_FREE, ADDR_W'($urandom_range(0, FRAME_BYTES - 1)));
                end else begin
                    send_request(CMD_FREE, ADDR_W'($urandom()));
                end
                // occasionally let the pipe run dry mid-phase
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
            drain();
        end
        steady_feed = 1'b0;
    endtask

    initial begin
        failed      = 1'b0;
        steady_feed = 1'b0;
        reserved_end = '0;
        for (int w = 0; w < WORD_COUNT; w++)
            used_words[w] = '0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= CMD_ALLOC;
        i_address   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_alloc();
        test_free_edges();
        test_partial_reserve();
        test_memory_full();
        test_reserve_all();
        test_random_traffic();

        // quiet period to catch stray results
        drain();
        repeat (600) @(posedge i_clk);
        if (!failed && pending_frames.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
